[hw/rtl/ssig_pkg.sv]
package ssig_pkg;

    localparam int GRID_W        = 9;
    localparam int IDX_W         = 16;
    localparam int MAX_GRID_SIZE = 256;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(68);
    localparam logic [GRID_W-1:0] GRID_MAX   = GRID_W'(MAX_GRID_SIZE);

    // Position inside the strip sequence
    typedef enum logic [4:0] {
        POS_START  = 5'b00001,
        POS_SECOND = 5'b00010,
        POS_PAIR_A = 5'b00100,
        POS_PAIR_B = 5'b01000,
        POS_DEGEN  = 5'b10000
    } t_pos;

    // Leg direction over the grid
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    // One result item
    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             last_index;
        logic             valid_res;
    } t_result;

endpackage

[hw/rtl/ssig_step.sv]
module ssig_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req,
    input  logic                          i_restart,
    input  logic [ssig_pkg::GRID_W-1:0]   i_grid_size,
    output ssig_pkg::t_result             o_result
);

    // sequence state
    logic [ssig_pkg::IDX_W-1:0]  r_rec0, r_rec1, r_rec2;
    logic [ssig_pkg::IDX_W-1:0]  n_rec0, n_rec1, n_rec2;
    logic [ssig_pkg::GRID_W-1:0] r_leg_len, n_leg_len;
    logic [ssig_pkg::GRID_W-1:0] r_pair_cnt, n_pair_cnt;
    ssig_pkg::t_dir              r_dir, n_dir;
    ssig_pkg::t_pos              r_pos, n_pos;
    logic                        r_finished, n_finished;

    // restart view of the state
    logic [ssig_pkg::IDX_W-1:0]  c_rec1, c_rec2;
    logic [ssig_pkg::GRID_W-1:0] c_leg_len, c_pair_cnt;
    ssig_pkg::t_dir              c_dir;
    ssig_pkg::t_pos              c_pos;
    logic                        c_finished;

    logic [ssig_pkg::IDX_W-1:0]  gs_ext;
    logic [ssig_pkg::IDX_W-1:0]  delta;
    logic [ssig_pkg::GRID_W-1:0] pair_inc;
    logic [ssig_pkg::GRID_W-1:0] len_dec;
    logic [ssig_pkg::IDX_W-1:0]  idx;
    logic                        last;
    logic                        valid;
    logic                        push;

    assign gs_ext = ssig_pkg::IDX_W'(i_grid_size);

    // restart clears the sequence before the step is taken
    always_comb begin
        if (i_restart) begin
            c_rec1     = '0;
            c_rec2     = '0;
            c_leg_len  = '0;
            c_pair_cnt = '0;
            c_dir      = ssig_pkg::DIR_RIGHT;
            c_pos      = ssig_pkg::POS_START;
            c_finished = 1'b0;
        end else begin
            c_rec1     = r_rec1;
            c_rec2     = r_rec2;
            c_leg_len  = r_leg_len;
            c_pair_cnt = r_pair_cnt;
            c_dir      = r_dir;
            c_pos      = r_pos;
            c_finished = r_finished;
        end
    end

    // per-leg step added to the index two places back
    always_comb begin
        unique case (c_dir)
            ssig_pkg::DIR_RIGHT: delta = ssig_pkg::IDX_W'(1);
            ssig_pkg::DIR_DOWN:  delta = gs_ext;
            ssig_pkg::DIR_LEFT:  delta = '1;
            ssig_pkg::DIR_UP:    delta = ssig_pkg::IDX_W'(0) - gs_ext;
            default:             delta = '0;
        endcase
    end

    assign pair_inc = c_pair_cnt + ssig_pkg::GRID_W'(1);
    assign len_dec  = (c_leg_len != '0) ? c_leg_len - ssig_pkg::GRID_W'(1) : '0;

    // one step of the spiral
    always_comb begin
        idx        = '0;
        last       = 1'b0;
        valid      = 1'b1;
        push       = 1'b0;
        n_leg_len  = c_leg_len;
        n_pair_cnt = c_pair_cnt;
        n_dir      = c_dir;
        n_pos      = c_pos;
        n_finished = c_finished;
        if (c_finished) begin
            valid = 1'b0;
        end else begin
            unique case (c_pos)
                ssig_pkg::POS_START: begin
                    idx   = '0;
                    push  = 1'b1;
                    n_pos = ssig_pkg::POS_SECOND;
                end
                ssig_pkg::POS_SECOND: begin
                    idx        = gs_ext;
                    push       = 1'b1;
                    n_leg_len  = (i_grid_size != '0) ?
                                 i_grid_size - ssig_pkg::GRID_W'(1) : '0;
                    n_dir      = ssig_pkg::DIR_RIGHT;
                    n_pair_cnt = '0;
                    if (n_leg_len == '0) begin
                        last       = 1'b1;
                        n_finished = 1'b1;
                    end else begin
                        n_pos = ssig_pkg::POS_PAIR_A;
                    end
                end
                ssig_pkg::POS_PAIR_A: begin
                    idx   = c_rec1 + delta;
                    push  = 1'b1;
                    n_pos = ssig_pkg::POS_PAIR_B;
                end
                ssig_pkg::POS_PAIR_B: begin
                    idx        = c_rec1 + delta;
                    push       = 1'b1;
                    n_pair_cnt = pair_inc;
                    n_pos      = (pair_inc >= c_leg_len) ? ssig_pkg::POS_DEGEN
                                                         : ssig_pkg::POS_PAIR_A;
                end
                ssig_pkg::POS_DEGEN: begin
                    idx        = c_rec2;
                    push       = 1'b1;
                    n_pair_cnt = '0;
                    // length shrinks after right and left legs
                    if (c_dir == ssig_pkg::DIR_RIGHT || c_dir == ssig_pkg::DIR_LEFT) begin
                        n_leg_len = len_dec;
                    end
                    if (c_dir == ssig_pkg::DIR_UP && n_leg_len == '0) begin
                        last       = 1'b1;
                        n_finished = 1'b1;
                    end else begin
                        n_dir = (c_dir == ssig_pkg::DIR_UP) ? ssig_pkg::DIR_RIGHT
                                                            : ssig_pkg::t_dir'(c_dir + 2'd1);
                        n_pos = (n_leg_len != '0) ? ssig_pkg::POS_PAIR_A
                                                  : ssig_pkg::POS_DEGEN;
                    end
                end
                default: begin
                    n_finished = 1'b1;
                    valid      = 1'b0;
                end
            endcase
        end
    end

    // history shift
    always_comb begin
        if (push) begin
            n_rec0 = idx;
            n_rec1 = i_restart ? '0 : r_rec0;
            n_rec2 = c_rec1;
        end else begin
            n_rec0 = i_restart ? '0 : r_rec0;
            n_rec1 = c_rec1;
            n_rec2 = c_rec2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec0     <= '0;
            r_rec1     <= '0;
            r_rec2     <= '0;
            r_leg_len  <= '0;
            r_pair_cnt <= '0;
            r_dir      <= ssig_pkg::DIR_RIGHT;
            r_pos      <= ssig_pkg::POS_START;
            r_finished <= 1'b1;
        end else if (i_req) begin
            r_rec0     <= n_rec0;
            r_rec1     <= n_rec1;
            r_rec2     <= n_rec2;
            r_leg_len  <= n_leg_len;
            r_pair_cnt <= n_pair_cnt;
            r_dir      <= n_dir;
            r_pos      <= n_pos;
            r_finished <= n_finished;
        end
    end

    assign o_result.vertex_index = idx;
    assign o_result.last_index   = last;
    assign o_result.valid_res    = valid;

endmodule

[hw/rtl/ssig_obuf.sv]
module ssig_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ssig_pkg::t_result  i_result,
    input  logic               i_taken,
    output logic               o_full,
    output ssig_pkg::t_result  o_result
);

    logic              r_full;
    ssig_pkg::t_result r_result;

    // occupancy: filled on load, emptied when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_taken) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_full   = r_full;
    assign o_result = r_result;

endmodule

[hw/rtl/spiral_strip_index_generator.sv]
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata[0] restart
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata vertex_index, tlast, tuser valid_res
// cfg      in   i_cfg_we (no wait)           i_cfg_wdata grid_size
//
// One request is taken per cycle while the output register is empty or m_axis_tready
// is high; its result is in the output register the next cycle. The sequence state
// advances from the registered state, which sets the one-request-per-cycle rate.
// A request is accepted while the held result is being taken.
// Reset (synchronous, active low) leaves the generator exhausted, grid_size 68.
module spiral_strip_index_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [0] restart
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [15:0] vertex_index
    output logic                          m_axis_tlast,
    output logic                          m_axis_tuser,   // [0] valid_res
    input  logic                          i_cfg_we,
    input  logic [ssig_pkg::GRID_W-1:0]   i_cfg_wdata
);

    logic [ssig_pkg::GRID_W-1:0] r_grid_size;
    logic                        req;
    logic                        full;
    ssig_pkg::t_result           step_res;
    ssig_pkg::t_result           out_res;

    // grid size register, saturated on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= ssig_pkg::GRID_RESET;
        end else if (i_cfg_we) begin
            r_grid_size <= (i_cfg_wdata > ssig_pkg::GRID_MAX) ? ssig_pkg::GRID_MAX
                                                               : i_cfg_wdata;
        end
    end

    assign s_axis_tready = !full || m_axis_tready;
    assign req           = s_axis_tvalid && s_axis_tready;

    ssig_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_restart   (s_axis_tdata[0]),
        .i_grid_size (r_grid_size),
        .o_result    (step_res)
    );

    ssig_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (req),
        .i_result (step_res),
        .i_taken  (m_axis_tready),
        .o_full   (full),
        .o_result (out_res)
    );

    assign m_axis_tvalid = full;
    assign m_axis_tdata  = out_res.vertex_index;
    assign m_axis_tlast  = out_res.last_index;
    assign m_axis_tuser  = out_res.valid_res;

endmodule
